@@ src/dual_wheel_incremental_pid_top_defines.svh @@
`ifndef DUAL_WHEEL_INCREMENTAL_PID_TOP_DEFINES_SVH
`define DUAL_WHEEL_INCREMENTAL_PID_TOP_DEFINES_SVH

// same-cycle implication
`define DWIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DWIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dwip_pkg.sv @@
package dwip_pkg;

  localparam int SPEED_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int ROUTE_W  = 3;
  localparam int DRIVE_W  = 13;
  localparam int FACTOR_W = 4;
  localparam int SCALED_W = 20;
  localparam int TARGET_W = 18;
  localparam int ERR_W    = 26;
  localparam int DP_W     = 27;
  localparam int DD_W     = 28;
  localparam int DELTA_W  = 30;
  localparam int CFG_IDX_W = 2;

  // input beat -> output register
  localparam int PIPE_STAGES = 6;

  // floor(y / 125) == (y * RECIP_M) >> RECIP_SHIFT for y < 2**25
  localparam int RECIP_SHIFT = 32;
  localparam logic [25:0] RECIP_M = 26'd34359739;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_SPEED = 2'd0,
    REG_GAIN_P     = 2'd1,
    REG_GAIN_I     = 2'd2,
    REG_GAIN_D     = 2'd3
  } cfg_reg_e;

  localparam logic [ROUTE_W-1:0] ROUTE_NORMAL   = 3'd0;
  localparam logic [ROUTE_W-1:0] ROUTE_UPHILL   = 3'd1;
  localparam logic [ROUTE_W-1:0] ROUTE_STOP     = 3'd2;
  localparam logic [ROUTE_W-1:0] ROUTE_MANEUVER = 3'd3;
  localparam logic [ROUTE_W-1:0] ROUTE_PARK     = 3'd4;

  // per-stage load strobes
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
    logic ld_out;
  } pipe_ld_t;

  // speed factor in tenths
  function automatic logic [FACTOR_W-1:0] route_factor(input logic [ROUTE_W-1:0] rc);
    logic [FACTOR_W-1:0] f;
    unique case (rc)
      ROUTE_NORMAL:   f = 4'd10;
      ROUTE_UPHILL:   f = 4'd12;
      ROUTE_STOP:     f = 4'd0;
      ROUTE_MANEUVER: f = 4'd5;
      ROUTE_PARK:     f = 4'd3;
      default:        f = 4'd10;
    endcase
    return f;
  endfunction

endpackage

@@ src/dual_wheel_incremental_pid_top.sv @@
// Throughput: one beat per cycle unless the output stalls; six stages
// (target scale, reciprocal divide, error history, gain multipliers,
// term sum, clamp/output register). A stalled output backs up only as far as
// the first empty stage.
// Reset clears config registers, error histories, stored drives and valids.
module dual_wheel_incremental_pid_top #(
  parameter int unsigned DRIVE_MAX = 5000
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [dwip_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [15:0]                            cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [dwip_pkg::SPEED_W-1:0]    left_measured_i,
  input  logic signed [dwip_pkg::SPEED_W-1:0]    right_measured_i,
  input  logic [dwip_pkg::ROUTE_W-1:0]           route_class_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [dwip_pkg::DRIVE_W-1:0]           left_drive_o,
  output logic [dwip_pkg::DRIVE_W-1:0]           right_drive_o
);

  localparam int NS = dwip_pkg::PIPE_STAGES;

  logic [dwip_pkg::SPEED_W-1:0] base_speed_q;
  logic [dwip_pkg::GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;

  logic [NS-1:0] vld_q, vld_d, en, feed, ld;
  dwip_pkg::pipe_ld_t            pipe_ld;
  logic [dwip_pkg::TARGET_W-1:0] target;
  logic                          zero;
  logic signed [dwip_pkg::DELTA_W-1:0] left_delta, right_delta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_speed_q <= '0;
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (dwip_pkg::cfg_reg_e'(cfg_idx_i))
        dwip_pkg::REG_BASE_SPEED: base_speed_q <= cfg_data_i;
        dwip_pkg::REG_GAIN_P:     gain_p_q     <= cfg_data_i;
        dwip_pkg::REG_GAIN_I:     gain_i_q     <= cfg_data_i;
        dwip_pkg::REG_GAIN_D:     gain_d_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a stage takes a beat when it is empty or its beat moves on
  always_comb begin
    en[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
    feed[0] = in_valid_i;
    for (int i = 1; i < NS; i++) begin
      feed[i] = vld_q[i-1];
    end
    for (int i = 0; i < NS; i++) begin
      ld[i]    = en[i] && feed[i];
      vld_d[i] = en[i] ? feed[i] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign pipe_ld = '{ld1: ld[0], ld2: ld[1], ld3: ld[2], ld4: ld[3], ld5: ld[4],
                     ld_out: ld[5]};

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NS-1];

  dwip_target u_target (
    .clk_i         (clk_i),
    .ld_i          (pipe_ld),
    .base_speed_i  (base_speed_q),
    .route_class_i (route_class_i),
    .target_o      (target),
    .zero_o        (zero)
  );

  dwip_lane u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ld_i     (pipe_ld),
    .meas_i   (left_measured_i),
    .target_i (target),
    .gain_p_i (gain_p_q),
    .gain_i_i (gain_i_q),
    .gain_d_i (gain_d_q),
    .delta_o  (left_delta)
  );

  dwip_lane u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ld_i     (pipe_ld),
    .meas_i   (right_measured_i),
    .target_i (target),
    .gain_p_i (gain_p_q),
    .gain_i_i (gain_i_q),
    .gain_d_i (gain_d_q),
    .delta_o  (right_delta)
  );

  dwip_merge #(
    .DRIVE_MAX (DRIVE_MAX)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ld_i          (pipe_ld),
    .zero_i        (zero),
    .left_delta_i  (left_delta),
    .right_delta_i (right_delta),
    .left_drive_o  (left_drive_o),
    .right_drive_o (right_drive_o)
  );

endmodule

@@ src/dwip_target.sv @@
module dwip_target (
  input  logic                                clk_i,
  input  dwip_pkg::pipe_ld_t                  ld_i,
  input  logic [dwip_pkg::SPEED_W-1:0]        base_speed_i,
  input  logic [dwip_pkg::ROUTE_W-1:0]        route_class_i,
  output logic [dwip_pkg::TARGET_W-1:0]       target_o,
  output logic                                zero_o
);

  localparam int YW = dwip_pkg::SCALED_W + 5;
  localparam int PW = YW + 26;

  logic [dwip_pkg::SCALED_W-1:0] scaled_q;
  logic [YW-1:0]                 y;
  logic [PW-1:0]                 prod;
  logic [dwip_pkg::TARGET_W-1:0] target_q;
  logic                          zero3_q, zero4_q, zero5_q;

  // base * factor10 * 32, then / 125
  assign y    = {scaled_q, 5'b0};
  assign prod = PW'(y) * PW'(dwip_pkg::RECIP_M);

  always_ff @(posedge clk_i) begin
    if (ld_i.ld1) begin
      scaled_q <= dwip_pkg::SCALED_W'(base_speed_i) *
                  dwip_pkg::SCALED_W'(dwip_pkg::route_factor(route_class_i));
    end
    if (ld_i.ld2) begin
      target_q <= prod[dwip_pkg::RECIP_SHIFT +: dwip_pkg::TARGET_W];
    end
    if (ld_i.ld3) begin
      zero3_q <= (target_q == '0);
    end
    if (ld_i.ld4) begin
      zero4_q <= zero3_q;
    end
    if (ld_i.ld5) begin
      zero5_q <= zero4_q;
    end
  end

  assign target_o = target_q;
  assign zero_o   = zero5_q;

endmodule

@@ src/dwip_lane.sv @@
module dwip_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dwip_pkg::pipe_ld_t                   ld_i,
  input  logic signed [dwip_pkg::SPEED_W-1:0]  meas_i,
  input  logic [dwip_pkg::TARGET_W-1:0]        target_i,
  input  logic [dwip_pkg::GAIN_W-1:0]          gain_p_i,
  input  logic [dwip_pkg::GAIN_W-1:0]          gain_i_i,
  input  logic [dwip_pkg::GAIN_W-1:0]          gain_d_i,
  output logic signed [dwip_pkg::DELTA_W-1:0]  delta_o
);

  localparam int GW  = dwip_pkg::GAIN_W + 1;
  localparam int PPW = GW + dwip_pkg::DP_W;
  localparam int PIW = GW + dwip_pkg::ERR_W;
  localparam int PDW = GW + dwip_pkg::DD_W;

  logic signed [dwip_pkg::SPEED_W-1:0] meas1_q, meas2_q;
  logic signed [dwip_pkg::ERR_W-1:0]   tgt_s, meas_q8, e0;
  logic signed [dwip_pkg::ERR_W-1:0]   e1_q, e2_q, e3_q;
  logic signed [dwip_pkg::DP_W-1:0]    dp, dp3_q;
  logic signed [dwip_pkg::DD_W-1:0]    dd, dd3_q;
  logic signed [GW-1:0]                gp, gi, gd;
  logic signed [PPW-1:0]               pp_d, pp_q;
  logic signed [PIW-1:0]               pi_d, pi_q;
  logic signed [PDW-1:0]               pd_d, pd_q;
  logic signed [PPW-16-1:0]            tp;
  logic signed [PIW-16-1:0]            ti;
  logic signed [PDW-16-1:0]            td;
  logic signed [dwip_pkg::DELTA_W-1:0] delta_d, delta_q;

  assign tgt_s   = $signed({8'h00, target_i});
  assign meas_q8 = dwip_pkg::ERR_W'($signed({meas2_q, 8'h00}));
  assign e0      = tgt_s - meas_q8;
  assign dp      = dwip_pkg::DP_W'(e0) - dwip_pkg::DP_W'(e1_q);
  assign dd      = dwip_pkg::DD_W'(e0) - (dwip_pkg::DD_W'(e1_q) <<< 1) +
                   dwip_pkg::DD_W'(e2_q);

  assign gp   = $signed({1'b0, gain_p_i});
  assign gi   = $signed({1'b0, gain_i_i});
  assign gd   = $signed({1'b0, gain_d_i});
  assign pp_d = PPW'(gp) * PPW'(dp3_q);
  assign pi_d = PIW'(gi) * PIW'(e3_q);
  assign pd_d = PDW'(gd) * PDW'(dd3_q);

  // divide by 65536, rounding toward zero
  assign tp = (PPW-16)'((pp_q + (pp_q[PPW-1] ? PPW'(65535) : PPW'(0))) >>> 16);
  assign ti = (PIW-16)'((pi_q + (pi_q[PIW-1] ? PIW'(65535) : PIW'(0))) >>> 16);
  assign td = (PDW-16)'((pd_q + (pd_q[PDW-1] ? PDW'(65535) : PDW'(0))) >>> 16);
  assign delta_d = dwip_pkg::DELTA_W'(tp) + dwip_pkg::DELTA_W'(ti) +
                   dwip_pkg::DELTA_W'(td);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q <= '0;
      e2_q <= '0;
    end else if (ld_i.ld3) begin
      e1_q <= e0;
      e2_q <= e1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld1) begin
      meas1_q <= meas_i;
    end
    if (ld_i.ld2) begin
      meas2_q <= meas1_q;
    end
    if (ld_i.ld3) begin
      e3_q  <= e0;
      dp3_q <= dp;
      dd3_q <= dd;
    end
    if (ld_i.ld4) begin
      pp_q <= pp_d;
      pi_q <= pi_d;
      pd_q <= pd_d;
    end
    if (ld_i.ld5) begin
      delta_q <= delta_d;
    end
  end

  assign delta_o = delta_q;

endmodule

@@ src/dwip_merge.sv @@
module dwip_merge #(
  parameter int unsigned DRIVE_MAX = 5000
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dwip_pkg::pipe_ld_t                   ld_i,
  input  logic                                 zero_i,
  input  logic signed [dwip_pkg::DELTA_W-1:0]  left_delta_i,
  input  logic signed [dwip_pkg::DELTA_W-1:0]  right_delta_i,
  output logic [dwip_pkg::DRIVE_W-1:0]         left_drive_o,
  output logic [dwip_pkg::DRIVE_W-1:0]         right_drive_o
);

  localparam logic signed [31:0] DriveMaxS = 32'(DRIVE_MAX);

  logic [dwip_pkg::DRIVE_W-1:0] left_prev_q, right_prev_q;
  logic [dwip_pkg::DRIVE_W-1:0] left_d, right_d;
  logic [dwip_pkg::DRIVE_W-1:0] left_q, right_q;

  function automatic logic [dwip_pkg::DRIVE_W-1:0] drive_next(
    input logic [dwip_pkg::DRIVE_W-1:0]        prev,
    input logic signed [dwip_pkg::DELTA_W-1:0] delta
  );
    logic signed [31:0] sum;
    logic signed [31:0] clamped;
    sum = 32'($signed({1'b0, prev})) + 32'(delta);
    priority if (sum < 0) begin
      clamped = '0;
    end else if (sum > DriveMaxS) begin
      clamped = DriveMaxS;
    end else begin
      clamped = sum;
    end
    return clamped[dwip_pkg::DRIVE_W-1:0];
  endfunction

  assign left_d  = zero_i ? '0 : drive_next(left_prev_q, left_delta_i);
  assign right_d = zero_i ? '0 : drive_next(right_prev_q, right_delta_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_prev_q  <= '0;
      right_prev_q <= '0;
    end else if (ld_i.ld_out) begin
      left_prev_q  <= left_d;
      right_prev_q <= right_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_out) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;

endmodule

@@ src/dwip_checker.sv @@
`include "dual_wheel_incremental_pid_top_defines.svh"

module dwip_checker #(
  parameter int unsigned DRIVE_MAX = 5000
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [dwip_pkg::DRIVE_W-1:0]        left_drive_o,
  input logic [dwip_pkg::DRIVE_W-1:0]        right_drive_o
);

  localparam logic [3:0] MaxInflight = 4'(dwip_pkg::PIPE_STAGES);

  logic [3:0] inflight_q;
  logic       in_beat, out_beat, out_stall, drives_ok;
  logic [2*dwip_pkg::DRIVE_W-1:0] drives;

  assign in_beat   = in_valid_i && in_ready_o;
  assign out_beat  = out_valid_o && out_ready_i;
  assign out_stall = out_valid_o && !out_ready_i;
  assign drives    = {left_drive_o, right_drive_o};
  assign drives_ok = (DRIVE_MAX > 8191) ||
                     ((left_drive_o <= DRIVE_MAX) && (right_drive_o <= DRIVE_MAX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 4'(in_beat) - 4'(out_beat);
    end
  end

  `DWIP_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(drives), "stalled beat changed")
  `DWIP_ASSERT_NOW(a_drive_range, out_valid_o, drives_ok, "drive above limit")
  `DWIP_ASSERT_NOW(a_no_phantom, out_valid_o, inflight_q != 4'd0, "output beat without input")
  `DWIP_ASSERT_NOW(a_depth, 1'b1, inflight_q <= MaxInflight, "more beats in flight than stages")

endmodule

bind dual_wheel_incremental_pid_top dwip_checker #(
  .DRIVE_MAX (DRIVE_MAX)
) u_dwip_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .left_drive_o  (left_drive_o),
  .right_drive_o (right_drive_o)
);

@@ tb/dual_wheel_incremental_pid_top_tb.sv @@
`timescale 1ns / 1ps

module dual_wheel_incremental_pid_top_tb;
  import dwip_pkg::*;

  localparam int unsigned DRIVE_MAX = 5000;
  localparam int CLK_PERIOD = 10;
  localparam int RANDOM_ITEMS = 1080;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 300;

  localparam logic [ROUTE_W-1:0] ROUTE_RSVD5 = 3'd5;
  localparam logic [ROUTE_W-1:0] ROUTE_RSVD6 = 3'd6;
  localparam logic [ROUTE_W-1:0] ROUTE_RSVD7 = 3'd7;

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic [DRIVE_W-1:0] drive_t;

  typedef struct packed {
    drive_t left;
    drive_t right;
  } drive_pair_t;

  typedef struct packed {
    logic [15:0] base;
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
  } gain_set_t;

  typedef struct packed {
    int                 gains_id;
    speed_t             left;
    speed_t             right;
    logic [ROUTE_W-1:0] route;
    bit                 fixed_out;
    drive_t             want_l;
    drive_t             want_r;
  } tick_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [15:0]          cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  speed_t               left_measured_i;
  speed_t               right_measured_i;
  logic [ROUTE_W-1:0]   route_class_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  drive_t               left_drive_o;
  drive_t               right_drive_o;

  dual_wheel_incremental_pid_top #(
    .DRIVE_MAX(DRIVE_MAX)
  ) i_dut (
    .*
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // controller model state
  logic [15:0]              cfg_base, cfg_kp, cfg_ki, cfg_kd;
  logic signed [ERR_W-1:0]  err_hist [2][2];
  drive_t                   last_drive [2];

  drive_pair_t drive_expect_q [$];
  int          mismatch_count = 0;
  bit          quiet_phase = 1'b0;
  int          hold_req = 0;
  int          hold_done = 0;

  localparam gain_set_t GAIN_SETS [5] = '{
    '{16'd0,     16'd0,     16'd0,     16'd0},
    '{16'hFFFF,  16'h0100,  16'h0080,  16'h0040},
    '{16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF},
    '{16'd1,     16'h0100,  16'h0100,  16'h0100},
    '{16'd1000,  16'h0200,  16'h0040,  16'h0000}
  };

  localparam int N_ROWS = 21;
  localparam tick_row_t TICK_ROWS [N_ROWS] = '{
    // registers at reset: zero target
    '{0, 16'sh7FFF, 16'sh8000, ROUTE_NORMAL,   1'b1, 13'd0, 13'd0},
    '{0, 16'sh8000, 16'sh7FFF, ROUTE_UPHILL,   1'b1, 13'd0, 13'd0},
    '{0, 16'sh0000, 16'shFFFF, ROUTE_RSVD7,    1'b1, 13'd0, 13'd0},
    // max base, moderate gains, every named route and reserved codes 5 and 6
    '{1, 16'sd700,  16'sd700,  ROUTE_NORMAL,   1'b0, 13'd0, 13'd0},
    '{1, 16'sd780,  16'sd790,  ROUTE_UPHILL,   1'b0, 13'd0, 13'd0},
    '{1, 16'sd0,    16'sd0,    ROUTE_STOP,     1'b1, 13'd0, 13'd0},
    '{1, 16'sd300,  16'sd350,  ROUTE_MANEUVER, 1'b0, 13'd0, 13'd0},
    '{1, 16'sd190,  16'sd200,  ROUTE_PARK,     1'b0, 13'd0, 13'd0},
    '{1, 16'sd650,  16'sd660,  ROUTE_RSVD5,    1'b0, 13'd0, 13'd0},
    '{1, 16'sh8000, 16'sh7FFF, ROUTE_NORMAL,   1'b0, 13'd0, 13'd0},
    '{1, 16'sh7FFF, 16'sh8000, ROUTE_RSVD6,    1'b0, 13'd0, 13'd0},
    // max gains: clamp both ways
    '{2, 16'sh8000, 16'sh8000, ROUTE_UPHILL,   1'b0, 13'd0, 13'd0},
    '{2, 16'sh7FFF, 16'sh7FFF, ROUTE_UPHILL,   1'b0, 13'd0, 13'd0},
    '{2, 16'sd0,    16'sd0,    ROUTE_NORMAL,   1'b0, 13'd0, 13'd0},
    // tiny base: target truncates to zero on park-in
    '{3, 16'sd0,    16'sd0,    ROUTE_PARK,     1'b1, 13'd0, 13'd0},
    '{3, 16'sd0,    16'sd0,    ROUTE_NORMAL,   1'b0, 13'd0, 13'd0},
    '{3, 16'shFFFF, 16'sd1,    ROUTE_MANEUVER, 1'b0, 13'd0, 13'd0},
    '{4, 16'sd5,    16'sd8,    ROUTE_NORMAL,   1'b0, 13'd0, 13'd0},
    '{4, 16'sd10,   16'sd10,   ROUTE_NORMAL,   1'b0, 13'd0, 13'd0},
    '{4, 16'sd12,   16'sd9,    ROUTE_UPHILL,   1'b0, 13'd0, 13'd0},
    '{4, 16'sh8000, 16'sh8000, ROUTE_PARK,     1'b0, 13'd0, 13'd0}
  };

  function automatic int speed_tenths(logic [ROUTE_W-1:0] rc);
    case (rc)
      ROUTE_UPHILL:   return 12;
      ROUTE_STOP:     return 0;
      ROUTE_MANEUVER: return 5;
      ROUTE_PARK:     return 3;
      default:        return 10;
    endcase
  endfunction

  function automatic drive_t pid_wheel(int w, longint target, speed_t meas);
    longint e0, e1, e2, tp, ti, td, sum;
    e0 = target - longint'(meas) * 256;
    e1 = longint'(err_hist[w][0]);
    e2 = longint'(err_hist[w][1]);
    tp = longint'(cfg_kp) * (e0 - e1) / 65536;
    ti = longint'(cfg_ki) * e0 / 65536;
    td = longint'(cfg_kd) * (e0 - 2 * e1 + e2) / 65536;
    sum = tp + ti + td + longint'(last_drive[w]);
    if (sum < 0) sum = 0;
    if (sum > longint'(DRIVE_MAX)) sum = longint'(DRIVE_MAX);
    err_hist[w][1] = err_hist[w][0];
    err_hist[w][0] = ERR_W'(e0);
    last_drive[w] = DRIVE_W'(sum);
    return last_drive[w];
  endfunction

  function automatic drive_pair_t predict_drives(speed_t l, speed_t r,
                                                 logic [ROUTE_W-1:0] rc);
    longint      target;
    drive_pair_t d;
    target = longint'(cfg_base) * speed_tenths(rc) * 256 / 1000;
    d.left = pid_wheel(0, target, l);
    d.right = pid_wheel(1, target, r);
    if (target == 0) begin
      d = '0;
      last_drive[0] = '0;
      last_drive[1] = '0;
    end
    return d;
  endfunction

  function automatic logic [15:0] pick_reg(bit is_base);
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3, 4: return is_base ? 16'($urandom_range(100, 20000))
                              : 16'($urandom_range(0, 16'h0300));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic speed_t pick_speed(logic [ROUTE_W-1:0] rc);
    int center;
    int v;
    center = int'(longint'(cfg_base) * speed_tenths(rc) / 1000);
    case ($urandom_range(0, 19))
      0: v = -32768;
      1: v = 32767;
      2: v = 0;
      3: v = -1;
      4, 5, 6, 7: v = int'($urandom_range(0, 65535)) - 32768;
      default: v = center + int'($urandom_range(0, 60)) - 30;
    endcase
    return v[15:0];
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 9);
    if (quiet_phase || r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 15);
    if (r < 10) return $urandom_range(1, 3);
    if (r < 15) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_BASE_SPEED: cfg_base = val;
      REG_GAIN_P:     cfg_kp = val;
      REG_GAIN_I:     cfg_ki = val;
      REG_GAIN_D:     cfg_kd = val;
    endcase
  endtask

  task automatic apply_gains(gain_set_t g);
    write_reg(REG_BASE_SPEED, g.base);
    write_reg(REG_GAIN_P, g.kp);
    write_reg(REG_GAIN_I, g.ki);
    write_reg(REG_GAIN_D, g.kd);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // drop valid, let the pipe empty out
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_STAGES + 2) @(posedge clk_i);
  endtask

  task automatic send_tick(speed_t l, speed_t r, logic [ROUTE_W-1:0] rc, int gap,
                           bit fixed_out, drive_pair_t want);
    drive_pair_t d;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    left_measured_i <= l;
    right_measured_i <= r;
    route_class_i <= rc;
    do @(posedge clk_i); while (!in_ready_o);
    d = predict_drives(l, r, rc);
    drive_expect_q.push_back(fixed_out ? want : d);
  endtask

  // output side: random backpressure plus one long hold on request
  initial begin
    int stall;
    stall = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_done != hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_done = hold_req;
        out_ready_i <= 1'b1;
      end else if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet_phase && $urandom_range(0, 3) == 0) stall = stall_len();
      end
    end
  end

  initial begin
    drive_pair_t exp_d;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (drive_expect_q.size() == 0) begin
          note_mismatch("unexpected beat, left_drive", left_drive_o, 0);
        end else begin
          exp_d = drive_expect_q.pop_front();
          if (left_drive_o !== exp_d.left)
            note_mismatch("left_drive", left_drive_o, exp_d.left);
          if (right_drive_o !== exp_d.right)
            note_mismatch("right_drive", right_drive_o, exp_d.right);
        end
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
        idle = 0;
      else
        idle++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int          cur_set;
    int          sent;
    int          n_ticks;
    int          phase;
    gain_set_t   g;
    speed_t      l, r;
    logic [ROUTE_W-1:0] rc;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_BASE_SPEED;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    left_measured_i = '0;
    right_measured_i = '0;
    route_class_i = ROUTE_NORMAL;
    cfg_base = '0;
    cfg_kp = '0;
    cfg_ki = '0;
    cfg_kd = '0;
    err_hist = '{default: '0};
    last_drive = '{default: '0};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    cur_set = 0;
    for (int i = 0; i < N_ROWS; i++) begin
      if (TICK_ROWS[i].gains_id != cur_set) begin
        settle();
        cur_set = TICK_ROWS[i].gains_id;
        apply_gains(GAIN_SETS[cur_set]);
      end
      send_tick(TICK_ROWS[i].left, TICK_ROWS[i].right, TICK_ROWS[i].route, gap_len(),
                TICK_ROWS[i].fixed_out, '{TICK_ROWS[i].want_l, TICK_ROWS[i].want_r});
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      g = '{pick_reg(1'b1), pick_reg(1'b0), pick_reg(1'b0), pick_reg(1'b0)};
      case (phase)
        1: g = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        2: g.base = 16'd0;
        3: begin
          g.kp = '0;
          g.ki = '0;
          g.kd = '0;
        end
        default: ;
      endcase
      apply_gains(g);
      quiet_phase = (phase % 4 == 3) || (phase == 4);
      // long output stall while input keeps coming: pipe fills, input backs up
      if (phase == 4) hold_req++;
      n_ticks = $urandom_range(60, 120);
      repeat (n_ticks) begin
        rc = ROUTE_W'($urandom_range(0, 7));
        l = pick_speed(rc);
        r = pick_speed(rc);
        send_tick(l, r, rc, gap_len(), 1'b0, '0);
      end
      sent += n_ticks;
      phase++;
    end
    settle();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
